FILE: hw/rtl/gbn_pkg.sv
// Shared types and constants of the go-back-N link controller.
package gbn_pkg;

	localparam int SEQ_BITS      = 6;
	localparam int PAYLOAD_WIDTH = 64;
	localparam int SEQ_MOD       = 1 << SEQ_BITS;
	localparam int SEQ_MAX       = SEQ_MOD - 1;

	typedef logic [SEQ_BITS-1:0]      seq_t;
	typedef logic [SEQ_BITS:0]        cnt_t;
	typedef logic [PAYLOAD_WIDTH-1:0] pay_t;

	// Event codes of an incoming request.
	typedef enum logic [2:0] {
		REQ_NEW   = 3'd0,
		REQ_LINK  = 3'd1,
		REQ_FRAME = 3'd2,
		REQ_DTMO  = 3'd3,
		REQ_ATMO  = 3'd4
	} req_e;

	// Kind of a received frame.
	typedef enum logic [1:0] {
		RX_DATA = 2'd0,
		RX_ACK  = 2'd1,
		RX_NAK  = 2'd2
	} rx_kind_e;

	// Kind of a result.
	typedef enum logic [2:0] {
		K_STATUS  = 3'd0,
		K_DATA    = 3'd1,
		K_ACK     = 3'd2,
		K_NAK     = 3'd3,
		K_DELIVER = 3'd4
	} out_kind_e;

	typedef struct packed {
		logic [2:0] req_type;
		pay_t       new_payload;
		logic       rx_good;
		logic [1:0] rx_kind;
		seq_t       rx_seq;
		seq_t       rx_ack;
		pay_t       rx_payload;
	} req_t;

	typedef struct packed {
		logic [2:0] out_kind;
		seq_t       out_seq;
		seq_t       out_ack;
		pay_t       out_payload;
		logic       ack_tmr_arm;
		seq_t       freed_from;
		seq_t       freed_count;
		logic       network_enable;
		logic       last;
	} res_t;

	// Controller to datapath.
	typedef struct packed {
		logic accept;
		logic load_walk;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic walk;
		logic walk_last;
	} sts_t;

endpackage

FILE: hw/rtl/gbn_req_if.sv
// Request channel of the go-back-N link controller.
interface gbn_req_if;
	logic          valid;
	logic          ready;
	gbn_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/gbn_res_if.sv
// Result channel of the go-back-N link controller.
interface gbn_res_if;
	logic          valid;
	logic          ready;
	gbn_pkg::res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/gbn_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gbn_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/gbn_ctrl.sv
// Controller state machine: request handshake, output slot and window resend sequencing.
module gbn_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          res_valid,
	input  logic          res_ready,
	input  gbn_pkg::sts_t sts,
	output gbn_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;
	logic   load;

	assign slot_free     = !out_valid_q || res_ready;
	assign req_ready     = (state_q == ST_IDLE) && slot_free;
	assign cmd.accept    = req_valid && req_ready;
	assign cmd.load_walk = (state_q == ST_OUT) && slot_free;
	assign load          = (cmd.accept && !sts.walk) || cmd.load_walk;
	assign res_valid     = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.accept && sts.walk) begin
						state_q <= ST_RD;
					end
				end
				// The registered store read of the oldest entry happens in this state.
				ST_RD: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (cmd.load_walk && sts.walk_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_rd_then_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD |=> state_q == ST_OUT)
		else $error("store read state not followed by output state");

	a_walk_ends: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_walk && sts.walk_last |=> state_q == ST_IDLE && out_valid_q)
		else $error("resend did not end after its final frame");

	a_no_accept_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && sts.walk |=> !req_ready)
		else $error("request taken while a resend was starting");

endmodule

FILE: hw/rtl/gbn_dp.sv
// Datapath: protocol state, event decode, payload store and output register.
module gbn_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  gbn_pkg::req_t req,
	input  gbn_pkg::cmd_t cmd,
	output gbn_pkg::sts_t sts,
	output gbn_pkg::res_t res
);

	gbn_pkg::seq_t oldest_q, nts_q, exp_q;
	gbn_pkg::cnt_t out_q;
	logic          lr_q, nak_q;

	gbn_pkg::seq_t ptr_q, cnt_q, ack_q, ff_q, fc_q;
	logic          ne_q;
	gbn_pkg::res_t res_q;

	gbn_pkg::seq_t oldest_n, nts_n, exp_n, ack_cur, d, fcnt, rack_plus, raddr;
	gbn_pkg::cnt_t out_n;
	logic          lr_n, nak_n, we_n, walk_req, walk;
	gbn_pkg::res_t item;
	gbn_pkg::res_t walk_item;
	gbn_pkg::pay_t rdata;

	always_comb begin
		oldest_n  = oldest_q;
		nts_n     = nts_q;
		exp_n     = exp_q;
		out_n     = out_q;
		lr_n      = lr_q;
		nak_n     = nak_q;
		we_n      = 1'b0;
		walk_req  = 1'b0;
		item      = '0;
		item.last = 1'b1;
		ack_cur   = exp_q - gbn_pkg::seq_t'(1);
		rack_plus = req.rx_ack + gbn_pkg::seq_t'(1);
		// Cumulative ack frees every frame from the oldest up to rx_ack when that
		// lies inside the window.
		d         = req.rx_ack - oldest_q;
		fcnt      = ({1'b0, d} < out_q) ? d + gbn_pkg::seq_t'(1) : '0;

		unique case (req.req_type)
			gbn_pkg::REQ_NEW: begin
				if (out_q < gbn_pkg::cnt_t'(gbn_pkg::SEQ_MAX)) begin
					we_n             = 1'b1;
					item.out_kind    = gbn_pkg::K_DATA;
					item.out_seq     = nts_q;
					item.out_ack     = ack_cur;
					item.out_payload = req.new_payload;
					nts_n            = nts_q + gbn_pkg::seq_t'(1);
					out_n            = out_q + gbn_pkg::cnt_t'(1);
					lr_n             = 1'b0;
				end
			end
			gbn_pkg::REQ_LINK: begin
				lr_n = 1'b1;
			end
			gbn_pkg::REQ_FRAME: begin
				if (!req.rx_good) begin
					if (nak_q) begin
						item.out_kind = gbn_pkg::K_NAK;
						item.out_ack  = ack_cur;
						nak_n         = 1'b0;
						lr_n          = 1'b0;
					end
				end else begin
					item.freed_from  = oldest_q;
					item.freed_count = fcnt;
					oldest_n         = oldest_q + fcnt;
					out_n            = out_q - {1'b0, fcnt};
					if (req.rx_kind == gbn_pkg::RX_DATA) begin
						if (req.rx_seq == exp_q) begin
							item.out_kind    = gbn_pkg::K_DELIVER;
							item.out_payload = req.rx_payload;
							item.ack_tmr_arm = 1'b1;
							exp_n            = exp_q + gbn_pkg::seq_t'(1);
							nak_n            = 1'b1;
						end else if (nak_q) begin
							item.out_kind = gbn_pkg::K_NAK;
							item.out_ack  = ack_cur;
							nak_n         = 1'b0;
							lr_n          = 1'b0;
						end
					end else if (req.rx_kind == gbn_pkg::RX_NAK && rack_plus == oldest_q) begin
						walk_req = 1'b1;
					end
				end
			end
			gbn_pkg::REQ_DTMO: begin
				walk_req = 1'b1;
			end
			gbn_pkg::REQ_ATMO: begin
				item.out_kind = gbn_pkg::K_ACK;
				item.out_ack  = ack_cur;
				lr_n          = 1'b0;
			end
			default: begin
			end
		endcase

		// An empty window resends nothing and leaves a status result.
		walk = walk_req && (out_q != '0);
		if (walk) begin
			lr_n = 1'b0;
		end
		item.network_enable = (out_n < gbn_pkg::cnt_t'(gbn_pkg::SEQ_MAX)) && lr_n;
	end

	always_comb begin
		walk_item                 = '0;
		walk_item.out_kind        = gbn_pkg::K_DATA;
		walk_item.out_seq         = ptr_q;
		walk_item.out_ack         = ack_q;
		walk_item.out_payload     = rdata;
		walk_item.freed_from      = ff_q;
		walk_item.freed_count     = fc_q;
		walk_item.network_enable  = ne_q;
		walk_item.last            = (cnt_q == gbn_pkg::seq_t'(1));
	end

	assign sts.walk      = walk;
	assign sts.walk_last = (cnt_q == gbn_pkg::seq_t'(1));
	assign raddr         = cmd.load_walk ? ptr_q + gbn_pkg::seq_t'(1) : ptr_q;
	assign res           = res_q;

	gbn_ram #(
		.WIDTH(gbn_pkg::PAYLOAD_WIDTH),
		.DEPTH(gbn_pkg::SEQ_MOD)
	) u_store (
		.clk  (clk),
		.we   (cmd.accept && we_n),
		.waddr(nts_q),
		.wdata(req.new_payload),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			nts_q    <= '0;
			exp_q    <= '0;
			out_q    <= '0;
			lr_q     <= 1'b0;
			nak_q    <= 1'b1;
			cnt_q    <= '0;
		end else if (cmd.accept) begin
			oldest_q <= oldest_n;
			nts_q    <= nts_n;
			exp_q    <= exp_n;
			out_q    <= out_n;
			lr_q     <= lr_n;
			nak_q    <= nak_n;
			cnt_q    <= out_q[gbn_pkg::SEQ_BITS-1:0];
		end else if (cmd.load_walk) begin
			cnt_q <= cnt_q - gbn_pkg::seq_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ptr_q <= oldest_q;
			ack_q <= ack_cur;
			ff_q  <= item.freed_from;
			fc_q  <= item.freed_count;
			ne_q  <= item.network_enable;
			if (!walk) begin
				res_q <= item;
			end
		end else if (cmd.load_walk) begin
			res_q <= walk_item;
			ptr_q <= ptr_q + gbn_pkg::seq_t'(1);
		end
	end

	a_window_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		nts_q == oldest_q + out_q[gbn_pkg::SEQ_BITS-1:0])
		else $error("next-to-send pointer out of step with the window");

	a_window_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_q <= gbn_pkg::cnt_t'(gbn_pkg::SEQ_MAX))
		else $error("outstanding count beyond the window size");

	a_walk_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_walk |-> cnt_q != '0)
		else $error("resend frame loaded with no frame left");

endmodule

FILE: hw/rtl/go_back_n_link_controller.sv
// Top level of the go-back-N link controller.
//
// Each request on req is one link event: a new packet from the network layer,
// link ready, a received frame (already CRC checked), a data timeout or an ack
// timeout. Each event gives one or more results on res, the final one marked
// by last: frames to send (data, ACK, NAK) carrying ack = expected - 1,
// delivered packets, and the cumulative-ack frees and network-enable flag,
// which are the same on every result of the event. CRC and timers are outside.
//
// A single-result event's result is loaded into the output register at the
// accepting edge and offered from the next cycle, so one request per cycle is
// sustained while res keeps up. A NAK for the oldest frame or a data timeout
// resends the whole window of N outstanding frames: req is held off from the
// accepting edge until the last frame is loaded, first for the registered
// store read, then while the frames go out one per cycle when res keeps up.
// When res stalls, the output register holds its result and req ready falls
// until the register can be emptied or refilled at once.
// Reset clears the window pointers, counts and link-ready flag and allows a
// NAK; the payload store is not cleared, since only written entries are read.
module go_back_n_link_controller (
	input logic        clk,
	input logic        arst_n,
	gbn_req_if.sink    req,
	gbn_res_if.source  res
);

	gbn_pkg::cmd_t cmd;
	gbn_pkg::sts_t sts;
	logic          req_ready;
	logic          res_valid;
	gbn_pkg::res_t res_data;

	// The controller owns the handshakes and the resend sequence.
	gbn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req_ready),
		.res_valid(res_valid),
		.res_ready(res.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath keeps the protocol state, the store and the output register.
	gbn_dp u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req.data),
		.cmd   (cmd),
		.sts   (sts),
		.res   (res_data)
	);

	assign req.ready = req_ready;
	assign res.valid = res_valid;
	assign res.data  = res_data;

endmodule
